>>> rtl/ivf_pkg.sv
// Shared types and codes for the IVF nearest vector search block.
package ivf_pkg;

	localparam int VALUE_BITS = 16;

	localparam logic [1:0] KIND_CENTROID = 2'd0;
	localparam logic [1:0] KIND_ITEM     = 2'd1;
	localparam logic [1:0] KIND_QUERY    = 2'd2;
	localparam logic [1:0] KIND_CLEAR    = 2'd3;

	localparam logic ANS_ASSIGN = 1'b0;
	localparam logic ANS_QUERY  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic [1:0] CFG_NUM_CENTROIDS = 2'd0;
	localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd1;

	typedef struct packed {
		logic [1:0]                   kind;
		logic [5:0]                   centroid_slot;
		logic [6:0]                   elem_index;
		logic signed [VALUE_BITS-1:0] elem_value;
		logic [31:0]                  item_key;
		logic                         last_elem;
	} request_t;

	typedef struct packed {
		logic        answer_kind;
		logic [5:0]  cluster;
		logic [31:0] match_id;
		logic        found;
		logic [1:0]  status;
	} result_t;

endpackage

>>> rtl/ivf_nearest_vector_search.sv
// IVF nearest vector search: vector stores, dot product pass engine and search sequencer.
// Element transfers are taken with start whenever busy is low.
// Centroid last element: busy for a norm pass over the centroid memory row.
// Item last element: one pass per centroid and a compare after each pass but the first.
// Query last element: centroid passes as above, a check of each stored item, and one pass
// per item in the cluster, each but the first compared; result strobes once, no stall.
// Reset clears item count and control, presets config; memories hold no reset state.
module ivf_nearest_vector_search #(
	parameter int MAX_DIM       = 128,
	parameter int MAX_CENTROIDS = 64,
	parameter int MAX_ITEMS     = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ivf_pkg::request_t request,
	output logic              result_valid,
	output ivf_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);
	localparam int VB     = ivf_pkg::VALUE_BITS;
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LEN_W  = $clog2(MAX_DIM + 1);
	localparam int CID_W  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
	localparam int K_W    = $clog2(MAX_CENTROIDS + 1);
	localparam int ROW_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int CDEPTH = MAX_CENTROIDS * MAX_DIM;
	localparam int IDEPTH = MAX_ITEMS * MAX_DIM;
	localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int IA_W   = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
	localparam int MAG_W  = 2 * VB - 1 + $clog2(MAX_DIM);
	localparam int DOT_W  = MAG_W + 1;
	localparam int PROD_W = 2 * VB;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DOT  = 3'd1;
	localparam logic [2:0] ST_CAND = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_NEXT = 3'd4;
	localparam logic [2:0] ST_QSEL = 3'd5;
	localparam logic [2:0] ST_QCHK = 3'd6;

	localparam logic [1:0] M_CNORM = 2'd0;
	localparam logic [1:0] M_ICENT = 2'd1;
	localparam logic [1:0] M_QCENT = 2'd2;
	localparam logic [1:0] M_QITEM = 2'd3;

	logic signed [VB-1:0] cmem [CDEPTH];
	logic [MAG_W-1:0]     cnorm [MAX_CENTROIDS];
	logic signed [VB-1:0] imem [IDEPTH];
	logic [MAG_W-1:0]     inorm [MAX_ITEMS];
	logic [31:0]          ikey [MAX_ITEMS];
	logic [CID_W-1:0]     iclus [MAX_ITEMS];
	logic signed [VB-1:0] qbuf [MAX_DIM];

	logic signed [VB-1:0] cmem_rd_q, imem_rd_q, qbuf_rd_q;
	logic [MAG_W-1:0]     cnorm_rd_q, inorm_rd_q;
	logic [31:0]          ikey_rd_q;
	logic [CID_W-1:0]     iclus_rd_q;

	logic [2:0]             state_q;
	logic [1:0]             mode_q;
	logic [6:0]             ncent_q;
	logic [7:0]             vlen_q;
	logic [CNT_W-1:0]       count_q;
	logic                   issue_q;
	logic [DIM_W-1:0]       e_q;
	logic [CID_W-1:0]       j_q;
	logic [ROW_W-1:0]       i_q;
	logic [CA_W-1:0]        cbase_q;
	logic [IA_W-1:0]        ibase_q;
	logic [CID_W-1:0]       slot_q;
	logic [31:0]            key_q;
	logic [CID_W-1:0]       clus_q;
	logic signed [DOT_W-1:0] acc_q;
	logic [MAG_W-1:0]       nacc_q;
	logic signed [DOT_W-1:0] cand_d_q, best_d_q;
	logic [MAG_W-1:0]       cand_n_q, best_n_q;
	logic [31:0]            cand_key_q, best_key_q;
	logic [CID_W-1:0]       best_j_q;
	logic                   have_q;
	logic                   res_v_q;
	ivf_pkg::result_t       res_q;

	logic                    rd_v_s1, rd_last_s1;
	logic signed [VB-1:0]    a_val, b_val;
	logic                    v_s2, last_s2, pass_done_q;
	logic signed [PROD_W-1:0] prod_s2, sq_s2;

	logic [LEN_W-1:0] len_eff;
	logic [DIM_W-1:0] len_m1;
	logic [K_W-1:0]   k_eff;
	logic [CID_W-1:0] k_m1;
	logic             accept, slot_ok, idx_ok, row_ok;
	logic [CA_W-1:0]  cw_addr, cr_addr;
	logic [IA_W-1:0]  iw_addr, ir_addr;
	logic             cmem_we, imem_we, qbuf_we, cnorm_we, item_we;
	logic             first, cmp_start, cmp_done, cmp_better;

	always_comb begin
		if (vlen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(vlen_q) > MAX_DIM) begin
			len_eff = LEN_W'(MAX_DIM);
		end else begin
			len_eff = LEN_W'(vlen_q);
		end
		if (ncent_q == '0) begin
			k_eff = K_W'(1);
		end else if (int'(ncent_q) > MAX_CENTROIDS) begin
			k_eff = K_W'(MAX_CENTROIDS);
		end else begin
			k_eff = K_W'(ncent_q);
		end
	end

	assign len_m1  = DIM_W'(len_eff - LEN_W'(1));
	assign k_m1    = CID_W'(k_eff - K_W'(1));
	assign busy    = state_q != ST_IDLE;
	assign accept  = start && !busy;
	assign slot_ok = int'(request.centroid_slot) < MAX_CENTROIDS;
	assign idx_ok  = int'(request.elem_index) < MAX_DIM;
	assign row_ok  = int'(count_q) < MAX_ITEMS;
	assign cw_addr = CA_W'(int'(request.centroid_slot) * MAX_DIM + int'(request.elem_index));
	assign iw_addr = IA_W'(int'(count_q) * MAX_DIM + int'(request.elem_index));
	assign cr_addr = cbase_q + CA_W'(e_q);
	assign ir_addr = ibase_q + IA_W'(e_q);

	assign cmem_we = accept && request.kind == ivf_pkg::KIND_CENTROID && slot_ok && idx_ok;
	assign imem_we = accept && request.kind == ivf_pkg::KIND_ITEM && row_ok && idx_ok;
	assign qbuf_we = accept && request.kind == ivf_pkg::KIND_QUERY && idx_ok;
	assign cnorm_we = state_q == ST_DOT && pass_done_q && mode_q == M_CNORM;
	assign item_we = state_q == ST_NEXT && mode_q == M_ICENT && j_q == k_m1;

	always_ff @(posedge clk) begin
		if (cmem_we) begin
			cmem[cw_addr] <= request.elem_value;
		end
		cmem_rd_q <= cmem[cr_addr];
	end

	always_ff @(posedge clk) begin
		if (cnorm_we) begin
			cnorm[slot_q] <= acc_q[MAG_W-1:0];
		end
		cnorm_rd_q <= cnorm[j_q];
	end

	always_ff @(posedge clk) begin
		if (imem_we) begin
			imem[iw_addr] <= request.elem_value;
		end
		imem_rd_q <= imem[ir_addr];
	end

	always_ff @(posedge clk) begin
		if (item_we) begin
			inorm[ROW_W'(count_q)] <= nacc_q;
			ikey[ROW_W'(count_q)]  <= key_q;
			iclus[ROW_W'(count_q)] <= best_j_q;
		end
		inorm_rd_q <= inorm[i_q];
		ikey_rd_q  <= ikey[i_q];
		iclus_rd_q <= iclus[i_q];
	end

	always_ff @(posedge clk) begin
		if (qbuf_we) begin
			qbuf[DIM_W'(request.elem_index)] <= request.elem_value;
		end
		qbuf_rd_q <= qbuf[e_q];
	end

	always_comb begin
		case (mode_q)
			M_CNORM: a_val = cmem_rd_q;
			M_ICENT: a_val = imem_rd_q;
			default: a_val = qbuf_rd_q;
		endcase
		b_val = (mode_q == M_QITEM) ? imem_rd_q : cmem_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1     <= 1'b0;
			rd_last_s1  <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			pass_done_q <= 1'b0;
		end else begin
			rd_v_s1     <= issue_q;
			rd_last_s1  <= issue_q && e_q == len_m1;
			v_s2        <= rd_v_s1;
			last_s2     <= rd_last_s1;
			pass_done_q <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_val * b_val;
		sq_s2   <= a_val * a_val;
	end

	assign first     = (mode_q == M_QITEM) ? !have_q : (j_q == '0);
	assign cmp_start = state_q == ST_CAND && !first;

	ivf_cmp #(.MAG_W(MAG_W)) u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmp_start),
		.dn     (cand_d_q),
		.nn     (cand_n_q),
		.db     (best_d_q),
		.nb     (best_n_q),
		.done   (cmp_done),
		.better (cmp_better)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= M_CNORM;
			ncent_q    <= 7'd1;
			vlen_q     <= 8'd128;
			count_q    <= '0;
			issue_q    <= 1'b0;
			e_q        <= '0;
			j_q        <= '0;
			i_q        <= '0;
			cbase_q    <= '0;
			ibase_q    <= '0;
			slot_q     <= '0;
			key_q      <= '0;
			clus_q     <= '0;
			acc_q      <= '0;
			nacc_q     <= '0;
			cand_d_q   <= '0;
			cand_n_q   <= '0;
			cand_key_q <= '0;
			best_d_q   <= '0;
			best_n_q   <= '0;
			best_key_q <= '0;
			best_j_q   <= '0;
			have_q     <= 1'b0;
			res_v_q    <= 1'b0;
			res_q      <= '0;
		end else begin
			res_v_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					ivf_pkg::CFG_NUM_CENTROIDS: ncent_q <= cfg_data[6:0];
					ivf_pkg::CFG_VECTOR_LENGTH: vlen_q  <= cfg_data;
					default: ;
				endcase
			end
			if (v_s2) begin
				acc_q  <= acc_q + DOT_W'(prod_s2);
				nacc_q <= nacc_q + MAG_W'($unsigned(sq_s2));
			end
			if (issue_q) begin
				e_q <= e_q + DIM_W'(1);
				if (e_q == len_m1) begin
					issue_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (request.kind)
							ivf_pkg::KIND_CLEAR: begin
								count_q <= '0;
							end
							ivf_pkg::KIND_CENTROID: begin
								if (slot_ok && request.last_elem) begin
									slot_q  <= CID_W'(request.centroid_slot);
									cbase_q <= CA_W'(int'(request.centroid_slot) * MAX_DIM);
									mode_q  <= M_CNORM;
									e_q     <= '0;
									issue_q <= 1'b1;
									acc_q   <= '0;
									nacc_q  <= '0;
									state_q <= ST_DOT;
								end
							end
							ivf_pkg::KIND_ITEM: begin
								if (request.last_elem) begin
									if (!row_ok) begin
										res_v_q <= 1'b1;
										res_q   <= '{answer_kind: ivf_pkg::ANS_ASSIGN,
										             cluster: 6'd0,
										             match_id: request.item_key,
										             found: 1'b0,
										             status: ivf_pkg::STATUS_FULL};
									end else begin
										key_q   <= request.item_key;
										ibase_q <= IA_W'(int'(count_q) * MAX_DIM);
										cbase_q <= '0;
										j_q     <= '0;
										mode_q  <= M_ICENT;
										e_q     <= '0;
										issue_q <= 1'b1;
										acc_q   <= '0;
										nacc_q  <= '0;
										state_q <= ST_DOT;
									end
								end
							end
							ivf_pkg::KIND_QUERY: begin
								if (request.last_elem) begin
									cbase_q <= '0;
									j_q     <= '0;
									mode_q  <= M_QCENT;
									e_q     <= '0;
									issue_q <= 1'b1;
									acc_q   <= '0;
									nacc_q  <= '0;
									state_q <= ST_DOT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DOT: begin
					if (pass_done_q) begin
						if (mode_q == M_CNORM) begin
							state_q <= ST_IDLE;
						end else begin
							cand_d_q <= acc_q;
							cand_n_q <= (mode_q == M_QITEM) ? inorm_rd_q : cnorm_rd_q;
							state_q  <= ST_CAND;
						end
					end
				end
				ST_CAND: begin
					if (first) begin
						best_d_q   <= cand_d_q;
						best_n_q   <= cand_n_q;
						best_j_q   <= j_q;
						best_key_q <= cand_key_q;
						have_q     <= 1'b1;
						state_q    <= ST_NEXT;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (cmp_done) begin
						if (cmp_better) begin
							best_d_q   <= cand_d_q;
							best_n_q   <= cand_n_q;
							best_j_q   <= j_q;
							best_key_q <= cand_key_q;
							have_q     <= 1'b1;
						end
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (mode_q == M_QITEM) begin
						if (CNT_W'(i_q) + CNT_W'(1) == count_q) begin
							res_v_q <= 1'b1;
							res_q   <= '{answer_kind: ivf_pkg::ANS_QUERY,
							             cluster: 6'(clus_q),
							             match_id: have_q ? best_key_q : 32'd0,
							             found: have_q,
							             status: have_q ? ivf_pkg::STATUS_OK
							                            : ivf_pkg::STATUS_EMPTY};
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + ROW_W'(1);
							ibase_q <= ibase_q + IA_W'(MAX_DIM);
							state_q <= ST_QSEL;
						end
					end else if (j_q == k_m1) begin
						if (mode_q == M_ICENT) begin
							count_q <= count_q + CNT_W'(1);
							res_v_q <= 1'b1;
							res_q   <= '{answer_kind: ivf_pkg::ANS_ASSIGN,
							             cluster: 6'(best_j_q),
							             match_id: key_q,
							             found: 1'b0,
							             status: ivf_pkg::STATUS_OK};
							state_q <= ST_IDLE;
						end else begin
							clus_q  <= best_j_q;
							mode_q  <= M_QITEM;
							i_q     <= '0;
							ibase_q <= '0;
							have_q  <= 1'b0;
							if (count_q == '0) begin
								res_v_q <= 1'b1;
								res_q   <= '{answer_kind: ivf_pkg::ANS_QUERY,
								             cluster: 6'(best_j_q),
								             match_id: 32'd0,
								             found: 1'b0,
								             status: ivf_pkg::STATUS_EMPTY};
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_QSEL;
							end
						end
					end else begin
						j_q     <= j_q + CID_W'(1);
						cbase_q <= cbase_q + CA_W'(MAX_DIM);
						e_q     <= '0;
						issue_q <= 1'b1;
						acc_q   <= '0;
						nacc_q  <= '0;
						state_q <= ST_DOT;
					end
				end
				ST_QSEL: begin
					state_q <= ST_QCHK;
				end
				ST_QCHK: begin
					if (iclus_rd_q == clus_q) begin
						cand_key_q <= ikey_rd_q;
						e_q        <= '0;
						issue_q    <= 1'b1;
						acc_q      <= '0;
						nacc_q     <= '0;
						state_q    <= ST_DOT;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;
endmodule

>>> rtl/ivf_mul.sv
// Shift-add sequential multiplier, one multiplier bit per cycle.
module ivf_mul #(
	parameter int A_W = 76,
	parameter int B_W = 38
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);
	localparam int P_W = A_W + B_W;
	localparam int C_W = $clog2(B_W + 1);

	logic [P_W-1:0] acc_q;
	logic [P_W-1:0] a_q;
	logic [B_W-1:0] b_q;
	logic [C_W-1:0] cnt_q;
	logic           run_q;
	logic           done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= C_W'(B_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - C_W'(1);
				if (cnt_q == C_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= P_W'(a);
			b_q   <= b;
		end else if (run_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

>>> rtl/ivf_cmp.sv
// Cosine order compare of a candidate against the best so far, without square roots.
module ivf_cmp #(
	parameter int MAG_W = 38
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [MAG_W:0] dn,
	input  logic [MAG_W-1:0]   nn,
	input  logic signed [MAG_W:0] db,
	input  logic [MAG_W-1:0]   nb,
	output logic               done,
	output logic               better
);
	localparam logic [2:0] CS_IDLE = 3'd0;
	localparam logic [2:0] CS_SQN  = 3'd1;
	localparam logic [2:0] CS_MULN = 3'd2;
	localparam logic [2:0] CS_SQB  = 3'd3;
	localparam logic [2:0] CS_MULB = 3'd4;

	localparam logic [1:0] RANK_NEG  = 2'd0;
	localparam logic [1:0] RANK_ZERO = 2'd1;
	localparam logic [1:0] RANK_POS  = 2'd2;

	logic signed [MAG_W:0] dn_e, db_e;
	logic [1:0]            rk_n, rk_b;
	logic [MAG_W-1:0]      mag_n, mag_b;
	logic                  quick;

	logic [2:0]            state_q;
	logic                  mstart_q;
	logic [2*MAG_W-1:0]    ma_q;
	logic [MAG_W-1:0]      mb_q;
	logic [MAG_W-1:0]      nn_q, nb_q, magb_q;
	logic [3*MAG_W-1:0]    wn_q;
	logic                  pos_q;
	logic                  done_q, better_q;
	logic                  mdone;
	logic [3*MAG_W-1:0]    mprod;

	always_comb begin
		dn_e  = (nn == '0) ? '0 : dn;
		db_e  = (nb == '0) ? '0 : db;
		rk_n  = dn_e[MAG_W] ? RANK_NEG : ((dn_e != '0) ? RANK_POS : RANK_ZERO);
		rk_b  = db_e[MAG_W] ? RANK_NEG : ((db_e != '0) ? RANK_POS : RANK_ZERO);
		mag_n = dn_e[MAG_W] ? MAG_W'(-dn_e) : MAG_W'(dn_e);
		mag_b = db_e[MAG_W] ? MAG_W'(-db_e) : MAG_W'(db_e);
		quick = (rk_n != rk_b) || (rk_n == RANK_ZERO);
	end

	ivf_mul #(.A_W(2 * MAG_W), .B_W(MAG_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart_q),
		.a      (ma_q),
		.b      (mb_q),
		.done   (mdone),
		.prod   (mprod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= CS_IDLE;
			mstart_q <= 1'b0;
			done_q   <= 1'b0;
			better_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			mstart_q <= 1'b0;
			case (state_q)
				CS_IDLE: begin
					if (start) begin
						if (quick) begin
							done_q   <= 1'b1;
							better_q <= rk_n > rk_b;
						end else begin
							mstart_q <= 1'b1;
							state_q  <= CS_SQN;
						end
					end
				end
				CS_SQN: begin
					if (mdone) begin
						mstart_q <= 1'b1;
						state_q  <= CS_MULN;
					end
				end
				CS_MULN: begin
					if (mdone) begin
						mstart_q <= 1'b1;
						state_q  <= CS_SQB;
					end
				end
				CS_SQB: begin
					if (mdone) begin
						mstart_q <= 1'b1;
						state_q  <= CS_MULB;
					end
				end
				CS_MULB: begin
					if (mdone) begin
						done_q   <= 1'b1;
						better_q <= pos_q ? (wn_q > mprod) : (wn_q < mprod);
						state_q  <= CS_IDLE;
					end
				end
				default: begin
					state_q <= CS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE && start) begin
			ma_q   <= (2 * MAG_W)'(mag_n);
			mb_q   <= mag_n;
			nn_q   <= nn;
			nb_q   <= nb;
			magb_q <= mag_b;
			pos_q  <= rk_n == RANK_POS;
		end else if (state_q == CS_SQN && mdone) begin
			ma_q <= mprod[2*MAG_W-1:0];
			mb_q <= nb_q;
		end else if (state_q == CS_MULN && mdone) begin
			wn_q <= mprod;
			ma_q <= (2 * MAG_W)'(magb_q);
			mb_q <= magb_q;
		end else if (state_q == CS_SQB && mdone) begin
			ma_q <= mprod[2*MAG_W-1:0];
			mb_q <= nn_q;
		end
	end

	assign done   = done_q;
	assign better = better_q;
endmodule

>>> rtl/ivf_checker.sv
// Port-level assertions for the IVF search block, with its bind.
module ivf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input ivf_pkg::request_t request,
	input logic              result_valid,
	input ivf_pkg::result_t  result
);
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !busy && !result_valid)
		else $error("busy or result during reset");

	a_centroid_elem: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.kind == ivf_pkg::KIND_CENTROID && !request.last_elem)
		|=> !busy && !result_valid)
		else $error("centroid element transfer caused work");

	a_query_search: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.kind == ivf_pkg::KIND_QUERY && request.last_elem)
		|=> busy && !result_valid)
		else $error("query did not start a search");

	a_query_found: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.answer_kind == ivf_pkg::ANS_QUERY)
		|-> result.found == (result.status == ivf_pkg::STATUS_OK))
		else $error("query found flag disagrees with status");

	a_assign_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.answer_kind == ivf_pkg::ANS_ASSIGN)
		|-> !result.found && result.status != ivf_pkg::STATUS_EMPTY)
		else $error("assignment result with query fields");
endmodule

bind ivf_nearest_vector_search ivf_checker u_ivf_checker (.*);
